// ----- rtl/dod_pkg.sv -----
// Shared types and constants for the dictionary operand decoder.
package dod_pkg;

  localparam int unsigned MaxSymbols = 33022;
  localparam int unsigned QueueDepth = 4;

  // Stream encoding constants
  localparam logic [7:0]  EscByte        = 8'hFF;
  localparam logic [15:0] WordIndexLimit = 16'h7FFF;
  localparam logic [15:0] WordRaw32      = 16'hFFFF;
  localparam logic [15:0] WordIndexBase  = 16'h00FF;

  typedef enum logic [1:0] {
    ErrNone  = 2'd0,
    ErrBad8  = 2'd1,
    ErrBad15 = 2'd2
  } err_e;

  typedef enum logic {
    ReqLoad = 1'b0,
    ReqByte = 1'b1
  } req_e;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    OpLoad   = 2'd0,  // write a dictionary entry
    OpLookup = 2'd1,  // read a dictionary entry, result ok
    OpResult = 2'd2   // result fully known already (raw value or error)
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] index;
    logic [31:0] value;
    err_e        err;
  } op_t;

endpackage

// ----- rtl/dod_in_if.sv -----
// Input channel: load items and stream bytes with valid/ready handshake.
interface dod_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] entry_index;
  logic [31:0] entry_value;
  logic [7:0]  stream_byte;

  modport source (
    output valid, req_type, entry_index, entry_value, stream_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_value, stream_byte,
    output ready
  );
endinterface

// ----- rtl/dod_out_if.sv -----
// Output channel: decoded operand results with valid/ready handshake.
interface dod_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] symbol_value;
  logic [1:0]  error_code;

  modport source (
    output valid, symbol_value, error_code,
    input  ready
  );
  modport sink (
    input  valid, symbol_value, error_code,
    output ready
  );
endinterface

// ----- rtl/dod_front.sv -----
// Front end: accepts beats, tracks the symbol phase and classifies work ops.
module dod_front #(
  parameter int unsigned MaxSymbols = dod_pkg::MaxSymbols
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dod_in_if.sink        in_ch,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          full_i,
  output logic          push_o,
  output dod_pkg::op_t  push_op_o
);

  typedef enum logic [6:0] {
    PhIdle   = 7'b0000001,
    PhWordLo = 7'b0000010,
    PhWordHi = 7'b0000100,
    PhRaw0   = 7'b0001000,
    PhRaw1   = 7'b0010000,
    PhRaw2   = 7'b0100000,
    PhRaw3   = 7'b1000000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [31:0]   partial_q, partial_d;
  logic [15:0]   sym_count_q;
  logic          accept;
  logic [15:0]   word;
  logic [15:0]   word_idx;
  logic          op_valid;
  dod_pkg::op_t  op;

  // Range check of a dictionary index against the count and the capacity
  function automatic dod_pkg::op_t classify(logic [15:0] idx, logic [15:0] count,
                                            dod_pkg::err_e err);
    dod_pkg::op_t res;
    res = '{kind: dod_pkg::OpResult, index: idx, value: '0, err: err};
    if ((idx < count) && (32'(idx) < MaxSymbols)) begin
      res.kind = dod_pkg::OpLookup;
      res.err  = dod_pkg::ErrNone;
    end
    return res;
  endfunction

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // Escape word: low byte held in partial, high byte arriving now
  assign word     = {in_ch.stream_byte, partial_q[7:0]};
  assign word_idx = word + dod_pkg::WordIndexBase;

  // Phase machine and op classification
  always_comb begin
    phase_d   = phase_q;
    partial_d = partial_q;
    op_valid  = 1'b0;
    op        = '{kind: dod_pkg::OpResult, index: '0, value: '0, err: dod_pkg::ErrNone};
    if (accept) begin
      if (in_ch.req_type == dod_pkg::ReqLoad) begin
        // slots beyond capacity are dropped here
        if (32'(in_ch.entry_index) < MaxSymbols) begin
          op_valid = 1'b1;
          op = '{kind: dod_pkg::OpLoad, index: in_ch.entry_index,
                 value: in_ch.entry_value, err: dod_pkg::ErrNone};
        end
      end else begin
        unique case (phase_q)
          PhWordLo: begin
            partial_d = {24'd0, in_ch.stream_byte};
            phase_d   = PhWordHi;
          end
          PhWordHi: begin
            partial_d = '0;
            phase_d   = PhIdle;
            if (word < dod_pkg::WordIndexLimit) begin
              op_valid = 1'b1;
              op = classify(word_idx, sym_count_q, dod_pkg::ErrBad15);
            end else if (word < dod_pkg::WordRaw32) begin
              op_valid = 1'b1;
              op.value = {17'd0, word[14:0]};
            end else begin
              phase_d = PhRaw0;
            end
          end
          PhRaw0: begin
            partial_d = {24'd0, in_ch.stream_byte};
            phase_d   = PhRaw1;
          end
          PhRaw1: begin
            partial_d[15:8] = in_ch.stream_byte;
            phase_d         = PhRaw2;
          end
          PhRaw2: begin
            partial_d[23:16] = in_ch.stream_byte;
            phase_d          = PhRaw3;
          end
          PhRaw3: begin
            op_valid  = 1'b1;
            op.value  = {in_ch.stream_byte, partial_q[23:0]};
            partial_d = '0;
            phase_d   = PhIdle;
          end
          default: begin
            // first byte of a symbol
            partial_d = '0;
            if (in_ch.stream_byte < dod_pkg::EscByte) begin
              op_valid = 1'b1;
              op = classify({8'd0, in_ch.stream_byte}, sym_count_q, dod_pkg::ErrBad8);
              phase_d = PhIdle;
            end else begin
              phase_d = PhWordLo;
            end
          end
        endcase
      end
    end
  end

  assign push_o    = op_valid;
  assign push_op_o = op;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      partial_q   <= '0;
      sym_count_q <= '0;
    end else begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
      if (cfg_we_i) begin
        sym_count_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ----- rtl/dod_queue.sv -----
// Short op queue between the front end and the back end.
module dod_queue #(
  parameter int unsigned Depth = dod_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dod_pkg::op_t  push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dod_pkg::op_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dod_pkg::op_t    slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ----- rtl/dod_back.sv -----
// Back end: dictionary memory, lookups and the registered result stage.
module dod_back #(
  parameter int unsigned MaxSymbols = dod_pkg::MaxSymbols
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  dod_pkg::op_t  op_i,
  output logic          pop_o,
  dod_out_if.source     out_ch
);

  localparam int unsigned IdxW = (MaxSymbols > 1) ? $clog2(MaxSymbols) : 1;

  logic [31:0]    symbol_table_q [MaxSymbols];
  logic [31:0]    rd_data_q;
  logic           res_valid_q, res_valid_d;
  logic           res_lookup_q;
  logic [31:0]    res_value_q;
  dod_pkg::err_e  res_err_q;
  logic           pop;
  logic [IdxW-1:0] idx;

  // Take the next op when the result stage is free or draining
  assign pop   = op_valid_i && (!res_valid_q || out_ch.ready);
  assign pop_o = pop;
  assign idx   = op_i.index[IdxW-1:0];

  // Dictionary memory: one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (pop && (op_i.kind == dod_pkg::OpLoad)) begin
      symbol_table_q[idx] <= op_i.value;
    end
    if (pop && (op_i.kind == dod_pkg::OpLookup)) begin
      rd_data_q <= symbol_table_q[idx];
    end
  end

  // Result stage valid
  always_comb begin
    res_valid_d = res_valid_q && !out_ch.ready;
    if (pop) begin
      res_valid_d = (op_i.kind == dod_pkg::OpLookup) || (op_i.kind == dod_pkg::OpResult);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_lookup_q <= (op_i.kind == dod_pkg::OpLookup);
      res_value_q  <= op_i.value;
      res_err_q    <= op_i.err;
    end
  end

  assign out_ch.valid        = res_valid_q;
  assign out_ch.symbol_value = res_lookup_q ? rd_data_q : res_value_q;
  assign out_ch.error_code   = res_err_q;

endmodule

// ----- rtl/dictionary_operand_decoder.sv -----
// Top level: dictionary operand decoder with decoupled front and back ends.
// Throughput: one beat per cycle on the input, one result per cycle on the output.
// After the beat that ends its symbol, a result passes through two registers
// (queue write, then dictionary read into the result register).
// Input stalls only when the 4-entry op queue is full; output stalls are absorbed by it.
// Reset clears the symbol phase, symbol count, queue and result valid;
// dictionary contents are undefined until loaded.
module dictionary_operand_decoder #(
  parameter int unsigned MaxSymbols = dod_pkg::MaxSymbols,
  parameter int unsigned QueueDepth = dod_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dod_in_if.sink      in_ch,
  dod_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic          push;
  dod_pkg::op_t  push_op;
  logic          full;
  logic          q_valid;
  dod_pkg::op_t  q_head;
  logic          pop;

  dod_front #(
    .MaxSymbols (MaxSymbols)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .push_op_o   (push_op)
  );

  dod_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .head_o    (q_head)
  );

  dod_back #(
    .MaxSymbols (MaxSymbols)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (q_head),
    .pop_o      (pop),
    .out_ch     (out_ch)
  );

endmodule

// ----- rtl/dod_checker.sv -----
// Port-level assertions for the dictionary operand decoder, bound to the top level.
module dod_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_symbol_value_i,
  input logic [1:0]  out_error_code_i
);

  // A pending result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_symbol_value_i) && $stable(out_error_code_i))
    else $error("result payload changed while stalled");

  // Only the three defined error codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_error_code_i == dod_pkg::ErrNone ||
                     out_error_code_i == dod_pkg::ErrBad8 ||
                     out_error_code_i == dod_pkg::ErrBad15))
    else $error("undefined error code");

  // Error results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_error_code_i != dod_pkg::ErrNone) |-> (out_symbol_value_i == '0))
    else $error("error result with nonzero value");

endmodule

bind dictionary_operand_decoder dod_checker u_dod_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_ch.valid),
  .out_ready_i        (out_ch.ready),
  .out_symbol_value_i (out_ch.symbol_value),
  .out_error_code_i   (out_ch.error_code)
);
